### hdl/log_frame_encoder_unit_macros.svh
// Assertion macros for the log frame encoder RTL.
`ifndef LOG_FRAME_ENCODER_UNIT_MACROS_SVH
`define LOG_FRAME_ENCODER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define LFE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("lfe assertion failed");
`define LFE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("lfe assertion failed");
`else
`define LFE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LFE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### hdl/lfe_pkg.sv
// Types and constants of the log frame encoder.
package lfe_pkg;

	localparam logic OP_START = 1'b0;
	localparam logic OP_DATA  = 1'b1;

	localparam logic [7:0] SYNC_BYTE_0 = 8'h64;
	localparam logic [7:0] SYNC_BYTE_1 = 8'h62;
	localparam logic [7:0] FRAME_ID    = 8'h00;

	localparam int HDR_BYTES = 6;
	localparam int MAX_BEATS = 8;
	localparam int CNT_W     = 4;

	localparam logic REG_LOG_CLASS = 1'b0;

	typedef struct packed {
		logic        operation;
		logic [15:0] payload_length;
		logic [7:0]  payload_byte;
	} req_beat_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_last;
	} rsp_beat_t;

	typedef struct packed {
		logic [MAX_BEATS-1:0][7:0] bytes;
		logic [MAX_BEATS-1:0]      last;
		logic [CNT_W-1:0]          count;
	} lfe_plan_t;

endpackage

### hdl/lfe_frame_build.sv
// Per-item frame logic: next state and the bytes one item emits.
module lfe_frame_build
	import lfe_pkg::*;
#(
	parameter int MAX_PAYLOAD = 120,
	parameter int REM_W = $clog2(MAX_PAYLOAD + 1)
) (
	input  req_beat_t         item,
	input  logic [7:0]        log_class,
	input  logic [REM_W-1:0]  rem_cur,
	input  logic [15:0]       sum_cur,
	output logic [REM_W-1:0]  rem_nxt,
	output logic [15:0]       sum_nxt,
	output lfe_plan_t         plan
);

	localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

	logic [15:0]      len_clamp;
	logic [15:0]      hdr_sum;
	logic [15:0]      data_sum;
	logic [REM_W-1:0] rem_dec;

	assign len_clamp = (item.payload_length > MAX_LEN) ? MAX_LEN : item.payload_length;
	assign hdr_sum   = 16'(FRAME_ID) + 16'(log_class) + {8'd0, len_clamp[7:0]}
		+ {8'd0, len_clamp[15:8]};
	assign data_sum  = sum_cur + {8'd0, item.payload_byte};
	assign rem_dec   = rem_cur - REM_W'(1);

	always_comb begin
		plan    = '0;
		rem_nxt = rem_cur;
		sum_nxt = sum_cur;
		unique case (item.operation)
			OP_START: begin
				plan.bytes[0] = SYNC_BYTE_0;
				plan.bytes[1] = SYNC_BYTE_1;
				plan.bytes[2] = FRAME_ID;
				plan.bytes[3] = log_class;
				plan.bytes[4] = len_clamp[7:0];
				plan.bytes[5] = len_clamp[15:8];
				plan.bytes[6] = hdr_sum[7:0];
				plan.bytes[7] = hdr_sum[15:8];
				plan.last[7]  = 1'b1;
				plan.count    = (len_clamp == 16'd0) ? CNT_W'(MAX_BEATS) : CNT_W'(HDR_BYTES);
				sum_nxt       = hdr_sum;
				rem_nxt       = REM_W'(len_clamp);
			end
			OP_DATA: begin
				if (rem_cur != '0) begin
					plan.bytes[0] = item.payload_byte;
					plan.bytes[1] = data_sum[7:0];
					plan.bytes[2] = data_sum[15:8];
					plan.last[2]  = 1'b1;
					plan.count    = (rem_dec == '0) ? CNT_W'(3) : CNT_W'(1);
					sum_nxt       = data_sum;
					rem_nxt       = rem_dec;
				end
			end
			default: begin
				plan = '0;
			end
		endcase
	end

endmodule

### hdl/log_frame_encoder_unit.sv
// Log frame encoder top level: config register, frame state and byte serializer.
//
//  channel  dir  handshake              payload
//  req      in   req_valid/req_stall    req_beat_t (operation, length, byte)
//  rsp      out  rsp_valid/rsp_stall    rsp_beat_t (frame_byte, frame_last)
//  cfg      in   APB psel/penable       log_class at byte address 0
//
// A data beat emits its byte in the cycle after acceptance: one item per cycle while rsp is not stalled.
// With rsp flowing, a start item or a closing data item stalls req until its bytes drain;
// the number of beats the item emits sets how long req stays stalled.
// The next item is taken in the cycle the last buffered byte leaves.
// Reset clears frame state, class and buffer count; no clearing pass.
// rsp_stall holds the buffer and stalls req while any byte waits.
`include "log_frame_encoder_unit_macros.svh"
module log_frame_encoder_unit
	import lfe_pkg::*;
#(
	parameter int MAX_PAYLOAD = 120
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_beat_t   req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_beat_t   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int REM_W = $clog2(MAX_PAYLOAD + 1);

	logic [7:0]       class_q;
	logic [REM_W-1:0] rem_q;
	logic [15:0]      sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       buf_q [MAX_BEATS];
	logic             last_q [MAX_BEATS];

	logic [REM_W-1:0] rem_nxt;
	logic [15:0]      sum_nxt;
	lfe_plan_t        plan;
	logic             req_take;
	logic             rsp_take;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_LOG_CLASS) ? {24'd0, class_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == REG_LOG_CLASS) begin
			class_q <= pwdata[7:0];
		end
	end

	lfe_frame_build #(
		.MAX_PAYLOAD(MAX_PAYLOAD),
		.REM_W(REM_W)
	) u_build (
		.item(req),
		.log_class(class_q),
		.rem_cur(rem_q),
		.sum_cur(sum_q),
		.rem_nxt(rem_nxt),
		.sum_nxt(sum_nxt),
		.plan(plan)
	);

	assign rsp_valid      = (cnt_q != '0);
	assign rsp_take       = rsp_valid && !rsp_stall;
	assign req_stall      = !((cnt_q == '0) || (cnt_q == CNT_W'(1) && rsp_take));
	assign req_take       = req_valid && !req_stall;
	assign rsp.frame_byte = buf_q[0];
	assign rsp.frame_last = last_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			sum_q <= '0;
			cnt_q <= '0;
		end else if (req_take) begin
			rem_q <= rem_nxt;
			sum_q <= sum_nxt;
			cnt_q <= plan.count;
		end else if (rsp_take) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			for (int i = 0; i < MAX_BEATS; i++) begin
				buf_q[i]  <= plan.bytes[i];
				last_q[i] <= plan.last[i];
			end
		end else if (rsp_take) begin
			for (int i = 0; i < MAX_BEATS - 1; i++) begin
				buf_q[i]  <= buf_q[i+1];
				last_q[i] <= last_q[i+1];
			end
		end
	end

	`LFE_ASSERT_IMP(a_take_when_drained, clk, arst_n, req_valid && !req_stall, cnt_q <= CNT_W'(1))
	`LFE_ASSERT_IMP(a_last_is_final, clk, arst_n, rsp_valid && rsp.frame_last, cnt_q == CNT_W'(1))
	`LFE_ASSERT_NEXT(a_burst_continues, clk, arst_n, rsp_take && cnt_q > CNT_W'(1), rsp_valid)
	`LFE_ASSERT_IMP(a_rem_bounded, clk, arst_n, 1'b1, rem_q <= REM_W'(MAX_PAYLOAD))

endmodule
